// File: src/qmtlp_pkg.sv
// Package for the quoted-message timeout line parser.
// Holds the character codes, event and error codes, phase type and result struct.
// Depends on nothing.
package qmtlp_pkg;

    localparam int TIMEOUT_BITS = 32;
    localparam int TMO_B = (TIMEOUT_BITS > 32) ? 32 : TIMEOUT_BITS;
    localparam logic [35:0] TMO_LIMIT = (36'd1 << TMO_B) - 36'd1;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] EV_BYTE    = 2'd0;
    localparam logic [1:0] EV_END     = 2'd1;
    localparam logic [1:0] EV_TIMEOUT = 2'd2;
    localparam logic [1:0] EV_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NO_COLON = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW = 3'd2;
    localparam logic [2:0] ERR_ZERO     = 3'd3;
    localparam logic [2:0] ERR_NO_LF    = 3'd4;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_MESSAGE = 6'b000010,
        PH_COLON   = 6'b000100,
        PH_DIGITS  = 6'b001000,
        PH_NEWLINE = 6'b010000,
        PH_HALT    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  message_byte;
        logic [31:0] timeout_value;
        logic [2:0]  error_code;
    } result_t;

endpackage

// File: src/qmtlp_in_reg.sv
// Input register of the quoted-message timeout line parser.
// Holds one accepted byte until the parse stage takes it; uses qmtlp_pkg.
module qmtlp_in_reg
    import qmtlp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_q
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready = !valid_reg || take;

    always_comb begin
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_q     = byte_reg;

endmodule

// File: src/qmtlp_parse.sv
// Parse stage of the quoted-message timeout line parser.
// Holds the phase, timeout accumulator and overflow flag; uses qmtlp_pkg.
module qmtlp_parse
    import qmtlp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] byte_q,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] accum_reg;
    logic [31:0] accum_next;
    logic        ovf_reg;
    logic        ovf_next;
    logic        is_digit;
    logic [3:0]  digit;
    logic [35:0] prod;

    assign is_digit = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
    assign digit    = 4'(byte_q - CH_ZERO);
    assign prod     = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                    + {32'd0, digit};

    always_comb begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        ovf_next   = ovf_reg;
        res_valid  = 1'b0;
        res        = '0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (byte_q == CH_QUOTE) begin
                    phase_next = PH_MESSAGE;
                    accum_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            PH_MESSAGE: begin
                res_valid = 1'b1;
                if (byte_q == CH_QUOTE) begin
                    phase_next     = PH_COLON;
                    res.event_kind = EV_END;
                end else begin
                    res.event_kind   = EV_BYTE;
                    res.message_byte = byte_q;
                end
            end
            PH_COLON: begin
                if (byte_q != CH_COLON) begin
                    res_valid      = 1'b1;
                    res.event_kind = EV_ERROR;
                    res.error_code = ERR_NO_COLON;
                    phase_next     = PH_HALT;
                end else begin
                    phase_next = PH_DIGITS;
                    accum_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    if (!ovf_reg) begin
                        if (prod > TMO_LIMIT) begin
                            ovf_next = 1'b1;
                        end else begin
                            accum_next = prod[31:0];
                        end
                    end
                end else begin
                    res_valid = 1'b1;
                    if (byte_q != CH_S) begin
                        res.event_kind = EV_ERROR;
                        res.error_code = ERR_BAD_CHAR;
                        phase_next     = PH_HALT;
                    end else if (ovf_reg) begin
                        res.event_kind = EV_ERROR;
                        res.error_code = ERR_OVERFLOW;
                        phase_next     = PH_HALT;
                    end else if (accum_reg == '0) begin
                        res.event_kind = EV_ERROR;
                        res.error_code = ERR_ZERO;
                        phase_next     = PH_HALT;
                    end else begin
                        res.event_kind    = EV_TIMEOUT;
                        res.timeout_value = accum_reg;
                        phase_next        = PH_NEWLINE;
                    end
                end
            end
            PH_NEWLINE: begin
                if (byte_q != CH_LF) begin
                    res_valid      = 1'b1;
                    res.event_kind = EV_ERROR;
                    res.error_code = ERR_NO_LF;
                    phase_next     = PH_HALT;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_HALT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            accum_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// File: src/qmtlp_out_reg.sv
// Result register of the quoted-message timeout line parser.
// Holds one result until the receiver takes it; uses qmtlp_pkg.
module qmtlp_out_reg
    import qmtlp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic        res_valid,
    input  result_t     res,
    output logic        space,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic [1:0]  m_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space = !valid_reg || m_tready;

    always_comb begin
        if (fire) begin
            valid_next = res_valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.event_kind;
    assign m_tdata  = {5'd0, res_reg.error_code, res_reg.timeout_value,
                       res_reg.message_byte};

endmodule

// File: src/quoted_message_timeout_line_parser_top.sv
// Top level of the quoted-message timeout line parser.
// Instantiates qmtlp_in_reg, qmtlp_parse and qmtlp_out_reg; uses qmtlp_pkg.
//
// The slave channel takes one text byte per transfer on s_tdata. The master
// channel gives at most one result per byte: m_tuser is the event kind
// (message byte, message end, timeout ready, error) and m_tdata carries the
// message byte, the timeout value and the error code.
// A byte passes the input register, the combinational parse logic and the
// result register, which presents its result on the master channel.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the single parse stage, whose phase and times-ten accumulator update together.
// Bytes that cause no result (skipped text, colon, digits, newline) are
// absorbed without any master transfer.
// When the receiver stalls, the result register holds and the byte in the
// input register waits; s_tready falls once both registers are occupied.
// After an error result the block ignores every byte until reset.
// Reset (aresetn low, synchronous) empties both registers, returns the parser
// to waiting for an opening quote and clears the accumulator.
module quoted_message_timeout_line_parser_top
    import qmtlp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] message_byte, [39:8] timeout_value,
                                   // [42:40] error_code, [47:43] zero
    output logic [1:0]  m_tuser    // [1:0] event_kind
);

    logic       byte_valid;
    logic [7:0] byte_q;
    logic       space;
    logic       fire;
    logic       res_valid;
    result_t    res;

    assign fire = byte_valid && space;

    qmtlp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (fire),
        .byte_valid (byte_valid),
        .byte_q     (byte_q)
    );

    qmtlp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .byte_q    (byte_q),
        .res_valid (res_valid),
        .res       (res)
    );

    qmtlp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (
        @(posedge aclk) disable iff (!aresetn) !byte_valid |-> s_tready
    ) else $error("s_tready low with an empty input register");

    a_timeout_nonzero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == EV_TIMEOUT) |-> (m_tdata[39:8] != 32'd0)
    ) else $error("timeout result with a zero value");

    a_clean_fields: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != EV_TIMEOUT) |-> (m_tdata[39:8] == 32'd0)
    ) else $error("timeout field set on a non-timeout result");

    a_error_code_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == EV_ERROR) |-> (m_tdata[42:40] <= ERR_NO_LF)
    ) else $error("error result with an undefined error code");
`endif

endmodule

// File: verif/quoted_message_timeout_line_parser_top_tb.sv
// Testbench for quoted_message_timeout_line_parser_top: drives entries of quoted text and
// timeouts, predicts each result in a small scoreboard and checks every master transfer.
// Depends on qmtlp_pkg and the parser RTL.
`timescale 1ns / 100ps

module quoted_message_timeout_line_parser_top_tb;
    import qmtlp_pkg::*;

    localparam int ENTRY_BYTES  = 1500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 400;

    class parse_scoreboard;
        phase_t      phase;
        logic [31:0] accum;
        bit          overflowed;
        result_t     pending_q[$];
        int          errors;

        function new();
            phase      = PH_IDLE;
            accum      = '0;
            overflowed = 1'b0;
            errors     = 0;
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] ch, logic [31:0] tmo,
                                  logic [2:0] code);
            result_t r;
            r.event_kind    = kind;
            r.message_byte  = ch;
            r.timeout_value = tmo;
            r.error_code    = code;
            pending_q.push_back(r);
        endfunction

        function void halt_with(logic [2:0] code);
            phase = PH_HALT;
            push_result(EV_ERROR, 8'd0, 32'd0, code);
        endfunction

        function void note_byte(logic [7:0] ch);
            logic [63:0] next_val;
            case (phase)
                PH_IDLE: begin
                    if (ch == CH_QUOTE) begin
                        phase      = PH_MESSAGE;
                        accum      = '0;
                        overflowed = 1'b0;
                    end
                end
                PH_MESSAGE: begin
                    if (ch == CH_QUOTE) begin
                        phase = PH_COLON;
                        push_result(EV_END, 8'd0, 32'd0, 3'd0);
                    end else begin
                        push_result(EV_BYTE, ch, 32'd0, 3'd0);
                    end
                end
                PH_COLON: begin
                    if (ch != CH_COLON) begin
                        halt_with(ERR_NO_COLON);
                    end else begin
                        phase      = PH_DIGITS;
                        accum      = '0;
                        overflowed = 1'b0;
                    end
                end
                PH_DIGITS: begin
                    if (ch >= CH_ZERO && ch <= CH_NINE) begin
                        if (!overflowed) begin
                            next_val = {32'd0, accum} * 64'd10 + {56'd0, ch - CH_ZERO};
                            if (next_val > {28'd0, TMO_LIMIT}) overflowed = 1'b1;
                            else accum = next_val[31:0];
                        end
                    end else if (ch != CH_S) begin
                        halt_with(ERR_BAD_CHAR);
                    end else if (overflowed) begin
                        halt_with(ERR_OVERFLOW);
                    end else if (accum == 32'd0) begin
                        halt_with(ERR_ZERO);
                    end else begin
                        phase = PH_NEWLINE;
                        push_result(EV_TIMEOUT, 8'd0, accum, 3'd0);
                    end
                end
                PH_NEWLINE: begin
                    if (ch != CH_LF) halt_with(ERR_NO_LF);
                    else phase = PH_IDLE;
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [47:0] data);
            result_t want;
            if (pending_q.size() == 0) begin
                $error("unexpected result: event_kind %0d, tdata %h", kind, data);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (kind !== want.event_kind) begin
                $error("event_kind: expected %0d, actual %0d", want.event_kind, kind);
                errors++;
            end
            if (data[7:0] !== want.message_byte) begin
                $error("message_byte: expected %h, actual %h", want.message_byte, data[7:0]);
                errors++;
            end
            if (data[39:8] !== want.timeout_value) begin
                $error("timeout_value: expected %0d, actual %0d", want.timeout_value,
                       data[39:8]);
                errors++;
            end
            if (data[42:40] !== want.error_code) begin
                $error("error_code: expected %0d, actual %0d", want.error_code, data[42:40]);
                errors++;
            end
            if (data[47:43] !== 5'd0) begin
                $error("padding: expected 0, actual %h", data[47:43]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    parse_scoreboard parse_sb = new();
    int bytes_sent = 0;
    int results_seen = 0;
    int cycle_count = 0;

    quoted_message_timeout_line_parser_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("quoted_message_timeout_line_parser_top test failed");
            $finish;
        end
    end

    // Every 128 draws, a stretch of 40 goes without any idling.
    function automatic int draw_gap(int seq);
        if ((seq % 128) < 40) return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [7:0] byte_other_than(logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == avoid);
        return b;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(bytes_sent);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        parse_sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic push_text(input string text);
        for (int i = 0; i < text.len(); i++) push_byte(text[i]);
    endtask

    task automatic push_message(input int len);
        push_byte(CH_QUOTE);
        for (int i = 0; i < len; i++) push_byte(byte_other_than(CH_QUOTE));
        push_byte(CH_QUOTE);
    endtask

    task automatic push_leading_zeros();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < n; i++) push_byte(CH_ZERO);
    endtask

    // Skipped bytes, a random message and a well-formed timeout line.
    task automatic push_entry();
        int skip;
        logic [31:0] tmo;
        skip = $urandom_range(0, 3);
        for (int i = 0; i < skip; i++) push_byte(byte_other_than(CH_QUOTE));
        push_message(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12));
        push_byte(CH_COLON);
        push_leading_zeros();
        case ($urandom_range(0, 3))
            0: tmo = 32'($urandom_range(1, 999));
            1: tmo = 32'hFFFF_FFFF;
            default: tmo = 32'($urandom_range(1, 32'hFFFF_FFFF));
        endcase
        push_text($sformatf("%0d", tmo));
        push_byte(CH_S);
        push_byte(CH_LF);
    endtask

    // A broken entry that ends in one of the five errors; the block then halts.
    task automatic push_broken_entry();
        logic [63:0] big;
        logic [7:0]  b;
        push_message($urandom_range(0, 6));
        case ($urandom_range(0, 4))
            0: push_byte(byte_other_than(CH_COLON));
            1: begin
                push_byte(CH_COLON);
                push_text($sformatf("%0d", $urandom_range(0, 999)));
                do b = 8'($urandom_range(0, 255));
                while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_S);
                push_byte(b);
            end
            2: begin
                push_byte(CH_COLON);
                push_leading_zeros();
                if ($urandom_range(0, 1) == 0) begin
                    push_text("4294967296");
                end else begin
                    big = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
                    push_text($sformatf("%0d", big));
                end
                push_text($sformatf("%0d", $urandom_range(0, 99)));
                push_byte(CH_S);
            end
            3: begin
                push_byte(CH_COLON);
                if ($urandom_range(0, 1) == 0) push_text("000");
                push_byte(CH_S);
            end
            default: begin
                push_byte(CH_COLON);
                push_text($sformatf("%0d", $urandom_range(1, 500)));
                push_byte(CH_S);
                push_byte(byte_other_than(CH_LF));
            end
        endcase
    endtask

    initial begin
        int hold;
        wait (aresetn === 1'b1);
        forever begin
            hold = (results_seen == HOLD_AT) ? HOLD_CYCLES : draw_gap(results_seen);
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            parse_sb.check_result(m_tuser, m_tdata);
            results_seen++;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // An empty message with the smallest timeout, then extreme bytes around
        // the quote and inside the message with the largest timeout.
        push_text("'':1s\n");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_QUOTE);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_QUOTE);
        push_text(":4294967295s\n");

        while (bytes_sent < ENTRY_BYTES) push_entry();
        push_broken_entry();

        // Once halted, even well-formed text must give nothing.
        push_text("'x':5s\n");
        for (int i = 0; i < 20; i++) push_byte(8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;

        while (parse_sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (parse_sb.errors == 0) begin
            $display("quoted_message_timeout_line_parser_top test passed");
        end else begin
            $display("quoted_message_timeout_line_parser_top test failed");
        end
        $finish;
    end

endmodule
